// ----- design/mbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared widths, codes and controller/datapath link types of the bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

  localparam int unsigned MaxFieldBits = 32;
  localparam int unsigned CapW         = 24;
  localparam int unsigned PosW         = 28;
  localparam int unsigned CntW         = 6;
  localparam int unsigned MultW        = 8;
  localparam int unsigned ValW         = 32;
  localparam int unsigned WinW         = MaxFieldBits + 8;
  localparam int unsigned LeftW        = 3;

  // remainder unit resolves this many dividend bits per cycle
  localparam int unsigned RemStepBits  = 4;
  localparam int unsigned RemSteps     = PosW / RemStepBits;
  localparam int unsigned RemCntW      = 3;

  localparam logic [CapW-1:0] CapReset = 24'd65536;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdAlign = 1'b1;

  typedef struct packed {
    logic load;
    logic rem_start;
    logic plan;
    logic build;
    logic shift;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic needs_rem;
    logic rem_done;
    logic last_word;
  } ctl_stat_t;

endpackage

// ----- design/msb_first_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs fields MSB first into a byte buffer and reports every touched byte.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one command word: tuser is the command (write or
//   align), tdata holds the field value, bit count and alignment multiple.
//   For each command the master stream gives one word per touched byte, in
//   address order, with the byte index and its full contents; the word with
//   tlast carries the dropped flag and the new bit position. A command that
//   writes nothing gives a single word with byte_valid low.
//   A write command gives k result words, k being 1 to 5. An align command
//   with a multiple of two or more also needs the bit position modulo the
//   multiple first; it comes from an iterative remainder unit that works
//   four bits per cycle. One command is in flight at a time; tready of the
//   slave side is high only when the last word of the previous one is gone.
//   A stalled master side holds the current word and the whole pipeline.
//   Reset clears the position and partial byte and sets the capacity to
//   65536 bytes; a write of the capacity register does the same with the new
//   capacity. Write it only while the block is idle.
// ----------------------------------------------------------------------------
module msb_first_bit_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mbp_pkg::CapW-1:0]    cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // field_value[31:0], bit_count[37:32], align_multiple[45:38], zero fill
  input  logic [47:0]                 s_axis_tdata,
  // cmd[0]
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // byte_index[23:0], byte_value[31:24], bit_position[59:32], zero fill
  output logic [63:0]                 m_axis_tdata,
  // byte_valid[0], dropped[1]
  output logic [1:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);

  mbp_pkg::ctl_cmd_t          ctl;
  mbp_pkg::ctl_stat_t         stat;
  logic [mbp_pkg::CapW-1:0]   byte_index;
  logic [7:0]                 byte_value;
  logic                       byte_valid;
  logic                       dropped;
  logic [mbp_pkg::PosW-1:0]   bit_position;

  mbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  mbp_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .cmd_i            (s_axis_tuser),
    .field_value_i    (s_axis_tdata[31:0]),
    .bit_count_i      (s_axis_tdata[37:32]),
    .align_multiple_i (s_axis_tdata[45:38]),
    .byte_index_o     (byte_index),
    .byte_value_o     (byte_value),
    .byte_valid_o     (byte_valid),
    .dropped_o        (dropped),
    .bit_position_o   (bit_position),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = {4'h0, bit_position, byte_value, byte_index};
  assign m_axis_tuser = {dropped, byte_valid};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input taken while a word is pending");

  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast && !m_axis_tuser[0])
    else $error("dropped flag on a non-final or byte word");

  a_inner_is_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser[0] && m_axis_tdata[59:32] == '0)
    else $error("inner word without byte or with position");

  a_empty_word_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[31:0] == '0)
    else $error("empty word carries byte data");

  a_next_byte_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
      m_axis_tvalid && m_axis_tdata[23:0] == $past(m_axis_tdata[23:0]) + 24'd1)
    else $error("byte index did not advance");

endmodule

// ----- design/mbp_rem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_rem
// Iterative remainder of the bit position by the alignment multiple.
// ----------------------------------------------------------------------------
module mbp_rem (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [mbp_pkg::PosW-1:0]        dividend_i,
  input  logic [mbp_pkg::MultW-1:0]       divisor_i,
  output logic                            busy_o,
  output logic [mbp_pkg::MultW-1:0]       rem_o
);

  logic                         busy_q, busy_d;
  logic [mbp_pkg::RemCntW-1:0]  cnt_q, cnt_d;
  logic [mbp_pkg::PosW-1:0]     dvd_q, dvd_d;
  logic [mbp_pkg::MultW-1:0]    rem_q, rem_d;
  logic [mbp_pkg::MultW-1:0]    div_q, div_d;
  logic [mbp_pkg::MultW-1:0]    acc;
  logic [mbp_pkg::MultW:0]      trial;

  // restoring steps, remainder stays below the divisor
  always_comb begin
    acc   = rem_q;
    trial = '0;
    for (int i = 0; i < int'(mbp_pkg::RemStepBits); i++) begin
      trial = {acc, dvd_q[mbp_pkg::PosW-1-i]};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      acc = trial[mbp_pkg::MultW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = acc;
      dvd_d = dvd_q << mbp_pkg::RemStepBits;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mbp_pkg::RemCntW'(mbp_pkg::RemSteps - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != '0 |-> rem_q < div_q)
    else $error("remainder not below divisor");

endmodule

// ----- design/mbp_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_dpath
// Position, partial byte, byte window and result registers of the packer.
// ----------------------------------------------------------------------------
module mbp_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mbp_pkg::CapW-1:0]      cfg_wdata_i,
  input  mbp_pkg::ctl_cmd_t             ctl_i,
  output mbp_pkg::ctl_stat_t            stat_o,
  input  logic                          cmd_i,
  input  logic [mbp_pkg::ValW-1:0]      field_value_i,
  input  logic [mbp_pkg::CntW-1:0]      bit_count_i,
  input  logic [mbp_pkg::MultW-1:0]     align_multiple_i,
  output logic [mbp_pkg::CapW-1:0]      byte_index_o,
  output logic [7:0]                    byte_value_o,
  output logic                          byte_valid_o,
  output logic                          dropped_o,
  output logic [mbp_pkg::PosW-1:0]      bit_position_o,
  output logic                          last_o
);

  localparam int unsigned WinW = mbp_pkg::WinW;

  logic [mbp_pkg::CapW-1:0]   cap_q;
  logic [mbp_pkg::PosW-1:0]   pos_q;
  logic [7:0]                 part_q;
  logic                       single_q;
  logic                       drop_q;
  logic [mbp_pkg::LeftW-1:0]  left_q;

  logic                       cmd_q;
  logic [mbp_pkg::ValW-1:0]   val_q;
  logic [mbp_pkg::CntW-1:0]   cnt_q;
  logic [mbp_pkg::MultW-1:0]  mult_q;
  logic [mbp_pkg::CntW-1:0]   n_q;
  logic [WinW-1:0]            win_q;
  logic [mbp_pkg::CapW-1:0]   idx_q;

  logic                       rem_busy;
  logic [mbp_pkg::MultW-1:0]  rem;

  logic [mbp_pkg::MultW-1:0]  n_full;
  logic [mbp_pkg::PosW:0]     pos_sum;
  logic [mbp_pkg::PosW:0]     limit;
  logic                       plan_drop;

  logic [2:0]                 off;
  logic [mbp_pkg::ValW:0]     mask_w;
  logic [mbp_pkg::ValW-1:0]   value;
  logic [5:0]                 sh;
  logic [5:0]                 span;
  logic [WinW-1:0]            win_d;
  logic [mbp_pkg::PosW-1:0]   new_pos;
  logic                       last_word;

  mbp_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.rem_start),
    .dividend_i (pos_q),
    .divisor_i  (mult_q),
    .busy_o     (rem_busy),
    .rem_o      (rem)
  );

  // bit count of the item and the drop check
  always_comb begin
    if (cmd_q == mbp_pkg::CmdAlign) begin
      if (mult_q <= 8'd1 || rem == '0) begin
        n_full = '0;
      end else begin
        n_full = mult_q - rem;
      end
    end else begin
      n_full = {2'b00, cnt_q};
    end
    pos_sum   = {1'b0, pos_q} + {{(mbp_pkg::PosW + 1 - mbp_pkg::MultW){1'b0}}, n_full};
    limit     = {2'b00, cap_q, 3'b000};
    plan_drop = (n_full > mbp_pkg::MultW'(mbp_pkg::MaxFieldBits)) ||
                ((n_full != '0) && (pos_sum > limit));
  end

  // byte window: partial byte on top, field bits right after it
  always_comb begin
    off     = pos_q[2:0];
    mask_w  = (33'd1 << n_q) - 33'd1;
    value   = (cmd_q == mbp_pkg::CmdAlign) ? '0 : (val_q & mask_w[mbp_pkg::ValW-1:0]);
    sh      = 6'(WinW) - {3'b000, off} - n_q;
    win_d   = {part_q, {(WinW - 8){1'b0}}} | ({8'h00, value} << sh);
    span    = {3'b000, off} + n_q + 6'd7;
    new_pos = pos_q + {{(mbp_pkg::PosW - mbp_pkg::CntW){1'b0}}, n_q};
  end

  assign last_word = single_q || (left_q == mbp_pkg::LeftW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= mbp_pkg::CapReset;
      pos_q    <= '0;
      part_q   <= '0;
      single_q <= 1'b1;
      drop_q   <= 1'b0;
      left_q   <= mbp_pkg::LeftW'(1);
    end else begin
      if (cfg_we_i) begin
        cap_q  <= cfg_wdata_i;
        pos_q  <= '0;
        part_q <= '0;
      end
      if (ctl_i.plan) begin
        drop_q   <= plan_drop;
        single_q <= plan_drop || (n_full == '0);
      end
      if (ctl_i.build) begin
        if (single_q) begin
          left_q <= mbp_pkg::LeftW'(1);
        end else begin
          left_q <= span[5:3];
          pos_q  <= new_pos;
        end
      end
      if (ctl_i.shift) begin
        left_q <= left_q - 1'b1;
      end
      // the last byte of the item becomes the partial byte
      if (ctl_i.finish && !single_q) begin
        part_q <= (pos_q[2:0] != 3'd0) ? win_q[WinW-1 -: 8] : 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q  <= cmd_i;
      val_q  <= field_value_i;
      cnt_q  <= bit_count_i;
      mult_q <= align_multiple_i;
    end
    if (ctl_i.plan) begin
      n_q <= plan_drop ? '0 : n_full[mbp_pkg::CntW-1:0];
    end
    if (ctl_i.build) begin
      win_q <= win_d;
      idx_q <= pos_q[mbp_pkg::CapW+2:3];
    end
    if (ctl_i.shift) begin
      win_q <= win_q << 8;
      idx_q <= idx_q + 1'b1;
    end
  end

  assign stat_o.needs_rem = (cmd_q == mbp_pkg::CmdAlign) && (mult_q > 8'd1);
  assign stat_o.rem_done  = !rem_busy;
  assign stat_o.last_word = last_word;

  assign byte_valid_o   = !single_q;
  assign byte_index_o   = single_q ? '0 : idx_q;
  assign byte_value_o   = single_q ? 8'h00 : win_q[WinW-1 -: 8];
  assign dropped_o      = drop_q;
  assign bit_position_o = last_word ? pos_q : '0;
  assign last_o         = last_word;

endmodule

// ----- design/mbp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_ctrl
// Sequencer of the packer: accept, remainder, plan, build, emit words.
// ----------------------------------------------------------------------------
module mbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  mbp_pkg::ctl_stat_t   stat_i,
  output mbp_pkg::ctl_cmd_t    ctl_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StRem   = 3'd2;
  localparam logic [2:0] StPlan  = 3'd3;
  localparam logic [2:0] StBuild = 3'd4;
  localparam logic [2:0] StEmit  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    ctl_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load = 1'b1;
          state_d    = StPrep;
        end
      end
      StPrep: begin
        if (stat_i.needs_rem) begin
          ctl_o.rem_start = 1'b1;
          state_d         = StRem;
        end else begin
          state_d = StPlan;
        end
      end
      StRem: begin
        if (stat_i.rem_done) begin
          state_d = StPlan;
        end
      end
      StPlan: begin
        ctl_o.plan = 1'b1;
        state_d    = StBuild;
      end
      StBuild: begin
        ctl_o.build = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (stat_i.last_word) begin
            ctl_o.finish = 1'b1;
            state_d      = StIdle;
          end else begin
            ctl_o.shift = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- tb/sv/msb_first_bit_packer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer_tb
// Drives write and align commands through the bit packer under random
// backpressure and capacity changes. A scoreboard predicts every touched byte,
// with its index, contents, status and new bit position, and checks each word.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_tb;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned NumPhases    = 16;
  localparam int unsigned PhaseItems   = 30;

  typedef struct packed {
    logic [mbp_pkg::CapW-1:0] byte_index;
    logic [7:0]               byte_value;
    logic                     byte_valid;
    logic                     dropped;
    logic [mbp_pkg::PosW-1:0] bit_position;
    logic                     last;
  } packed_word_t;

  class pack_scoreboard;
    logic [mbp_pkg::CapW-1:0] capacity;
    logic [mbp_pkg::PosW-1:0] position;
    logic [7:0]               partial;
    packed_word_t             touched_bytes_q[$];
    int                       errors;

    function new();
      capacity = mbp_pkg::CapReset;
      position = '0;
      partial  = '0;
      errors   = 0;
    endfunction

    function void write_capacity(logic [mbp_pkg::CapW-1:0] cap);
      capacity = cap;
      position = '0;
      partial  = '0;
    endfunction

    function int pending();
      return touched_bytes_q.size();
    endfunction

    // single status word, no byte carried
    function void push_status(logic drop);
      packed_word_t w;
      w = '0;
      w.dropped      = drop;
      w.bit_position = position;
      w.last         = 1'b1;
      touched_bytes_q.push_back(w);
    endfunction

    function void note_command(logic cmd, logic [31:0] value, logic [5:0] count,
                               logic [7:0] mult);
      logic [63:0]              room;
      logic [63:0]              limit;
      int unsigned              n;
      int unsigned              off;
      int unsigned              k;
      logic [7:0]               cur;
      logic [mbp_pkg::CapW-1:0] idx;
      packed_word_t             run [8];
      limit = 64'(capacity) * 64'd8;
      room  = (limit > 64'(position)) ? limit - 64'(position) : 64'd0;
      if (cmd == mbp_pkg::CmdAlign) begin
        if (mult <= 8'd1) begin
          push_status(1'b0);
          return;
        end
        n = (32'(mult) - 32'(position % 28'(mult))) % 32'(mult);
        value = '0;
      end else begin
        n = 32'(count);
      end
      if (n > mbp_pkg::MaxFieldBits || 64'(n) > room) begin
        push_status(1'b1);
        return;
      end
      if (n == 0) begin
        push_status(1'b0);
        return;
      end
      off = 32'(position[2:0]);
      idx = position[mbp_pkg::PosW-1:3];
      cur = partial;
      k   = 0;
      for (int i = int'(n) - 1; i >= 0; i--) begin
        cur[7 - off] = cur[7 - off] | value[i];
        off++;
        if (off == 8) begin
          run[k] = '0;
          run[k].byte_index = idx;
          run[k].byte_value = cur;
          run[k].byte_valid = 1'b1;
          k++;
          cur = '0;
          off = 0;
          idx++;
        end
      end
      // trailing partial byte is reported too
      if (off != 0) begin
        run[k] = '0;
        run[k].byte_index = idx;
        run[k].byte_value = cur;
        run[k].byte_valid = 1'b1;
        k++;
      end
      position = position + mbp_pkg::PosW'(n);
      partial  = (position[2:0] != 3'd0) ? cur : 8'd0;
      run[k-1].bit_position = position;
      run[k-1].last         = 1'b1;
      for (int j = 0; j < int'(k); j++) touched_bytes_q.push_back(run[j]);
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic [63:0] data, logic [1:0] flags, logic last);
      packed_word_t want;
      if (touched_bytes_q.size() == 0) begin
        $error("unexpected word: byte_index 0x%0h", data[23:0]);
        errors++;
        return;
      end
      want = touched_bytes_q.pop_front();
      compare("byte_index", 32'(want.byte_index), 32'(data[23:0]));
      compare("byte_value", 32'(want.byte_value), 32'(data[31:24]));
      compare("bit_position", 32'(want.bit_position), 32'(data[59:32]));
      compare("byte_valid", 32'(want.byte_valid), 32'(flags[0]));
      compare("dropped", 32'(want.dropped), 32'(flags[1]));
      compare("last", 32'(want.last), 32'(last));
    endfunction
  endclass

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [mbp_pkg::CapW-1:0] cfg_wdata_i = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  // field_value[31:0], bit_count[37:32], align_multiple[45:38], zero fill
  logic [47:0]              s_axis_tdata = '0;
  // cmd[0]
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  // byte_index[23:0], byte_value[31:24], bit_position[59:32], zero fill
  logic [63:0]              m_axis_tdata;
  // byte_valid[0], dropped[1]
  logic [1:0]               m_axis_tuser;
  logic                     m_axis_tlast;

  pack_scoreboard  sb = new();
  bit              tx_idle_on = 1'b1;
  bit              rx_idle_on = 1'b1;
  bit              rx_hold_request = 1'b0;
  int unsigned     cycle_count = 0;

  msb_first_bit_packer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // everything is sampled from the bus, values before the edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_capacity(cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_command(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[37:32],
                        s_axis_tdata[45:38]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_word(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      end
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    @(posedge clk_i);
    forever begin
      if (rx_hold_request) begin
        rx_hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        for (int c = 0; c < int'(HoldCycles); c++) @(posedge clk_i);
      end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_command(input logic cmd, input logic [31:0] value,
                              input logic [5:0] count, input logic [7:0] mult);
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, mult, count, value};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic sender_gap();
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every predicted word is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [mbp_pkg::CapW-1:0] cap);
    cfg_wdata_i <= cap;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random();
    logic        cmd;
    logic [31:0] value;
    logic [5:0]  count;
    logic [7:0]  mult;
    cmd   = ($urandom_range(0, 3) == 0) ? mbp_pkg::CmdAlign : mbp_pkg::CmdWrite;
    value = $urandom;
    case ($urandom_range(0, 7))
      0: value = '1;
      1: value = '0;
      default: ;
    endcase
    count = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
                                        : 6'($urandom_range(0, 32));
    mult  = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 33));
    send_command(cmd, value, count, mult);
    sender_gap();
  endtask

  initial begin
    logic [mbp_pkg::CapW-1:0] cap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(mbp_pkg::CmdWrite, 32'h0000_0001, 6'd0, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'h0000_0001, 6'd1, 8'd0);
    // full-width word at an odd offset spans five bytes
    send_command(mbp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd32, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'hFFFF_FFFF, 6'd33, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'h1234_5678, 6'd63, 8'hFF);
    send_command(mbp_pkg::CmdAlign, 32'hFFFF_FFFF, 6'd63, 8'd0);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd1);
    // padding longer than a field is rejected
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd255);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd8);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd8);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd2);
    send_command(mbp_pkg::CmdWrite, 32'h0000_0055, 6'd7, 8'd0);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd48);
    send_command(mbp_pkg::CmdWrite, 32'h8000_0001, 6'd32, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'h0000_0000, 6'd32, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'hFFFF_FFE0, 6'd5, 8'd0);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd3);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd128);
    drain();

    // tiny buffer: fill it, then overflow on write and on padding
    write_capacity(24'd2);
    send_command(mbp_pkg::CmdWrite, 32'h0000_A5C3, 6'd16, 8'd0);
    send_command(mbp_pkg::CmdWrite, 32'h0000_0001, 6'd1, 8'd0);
    send_command(mbp_pkg::CmdAlign, 32'h0, 6'd0, 8'd32);
    send_command(mbp_pkg::CmdWrite, 32'h0000_0000, 6'd0, 8'd0);

    for (int ph = 0; ph < int'(NumPhases); ph++) begin
      drain();
      case (ph)
        0: cap = '1;
        1: cap = '0;
        2: cap = 24'd1;
        15: cap = mbp_pkg::CapReset;
        default: cap = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                   : 24'($urandom_range(2, 48));
      endcase
      write_capacity(cap);
      rx_idle_on = (ph < int'(NumPhases) - 2);
      tx_idle_on = (ph < int'(NumPhases) - 2) && (ph != 4);
      // long result stall while commands keep coming
      if (ph == 4) rx_hold_request = 1'b1;
      repeat (PhaseItems) send_random();
    end

    drain();
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- files.f -----
design/mbp_pkg.sv
design/mbp_rem.sv
design/mbp_dpath.sv
design/mbp_ctrl.sv
design/msb_first_bit_packer.sv
tb/sv/msb_first_bit_packer_tb.sv
